@@ rtl/dro_pkg.sv @@
// ----------------------------------------------------------------------------
// dro_pkg
// Shared types, constants and tables of the planar dead-reckoning block.
// ----------------------------------------------------------------------------
package dro_pkg;

	localparam int CORDIC_STEPS_DEF = 16;
	localparam int MAX_STEPS        = 24;
	localparam int ATAN_IDX_W       = 5;
	localparam int AW               = 42;
	localparam int ZW               = 36;
	localparam int CFG_IDX_W        = 2;
	localparam int CFG_DATA_W       = 16;
	localparam int DIV_N            = 53;
	localparam int DIV_D            = 32;
	localparam int MUL_A_W          = 34;
	localparam int MUL_B_W          = 27;
	localparam int MUL_P_W          = MUL_A_W + MUL_B_W;

	localparam logic [CFG_IDX_W-1:0] REG_MOUNT_QX = 2'd0;
	localparam logic [CFG_IDX_W-1:0] REG_MOUNT_QY = 2'd1;
	localparam logic [CFG_IDX_W-1:0] REG_MOUNT_QZ = 2'd2;
	localparam logic [CFG_IDX_W-1:0] REG_MOUNT_QW = 2'd3;

	localparam logic signed [15:0] MOUNT_QW_RST = 16'sd32767;

	localparam logic signed [ZW-1:0] PI_Q30     = 36'sd3373259426;
	localparam logic signed [ZW-1:0] HALFPI_Q30 = 36'sd1686629713;
	localparam logic signed [ZW-1:0] TWOPI_Q30  = 36'sd6746518852;
	localparam logic signed [AW-1:0] GAIN_Q30   = 42'sd652032874;

	localparam logic signed [MUL_B_W-1:0] SPEED_SCALE = 27'sd1000000;

	typedef struct packed {
		logic start;
		logic rot;
	} cordic_ctl_t;

	function automatic logic [29:0] atan_q30(input logic [ATAN_IDX_W-1:0] i);
		logic [29:0] r;
		case (i)
			5'd0:    r = 30'd843314857;
			5'd1:    r = 30'd497837829;
			5'd2:    r = 30'd263043837;
			5'd3:    r = 30'd133525159;
			5'd4:    r = 30'd67021687;
			5'd5:    r = 30'd33543516;
			5'd6:    r = 30'd16775851;
			5'd7:    r = 30'd8388437;
			5'd8:    r = 30'd4194283;
			5'd9:    r = 30'd2097149;
			5'd10:   r = 30'd1048576;
			5'd11:   r = 30'd524288;
			5'd12:   r = 30'd262144;
			5'd13:   r = 30'd131072;
			5'd14:   r = 30'd65536;
			5'd15:   r = 30'd32768;
			5'd16:   r = 30'd16384;
			5'd17:   r = 30'd8192;
			5'd18:   r = 30'd4096;
			5'd19:   r = 30'd2048;
			5'd20:   r = 30'd1024;
			5'd21:   r = 30'd512;
			5'd22:   r = 30'd256;
			5'd23:   r = 30'd128;
			default: r = 30'd0;
		endcase
		return r;
	endfunction

	function automatic logic signed [31:0] sat32(input logic signed [39:0] v);
		logic signed [31:0] r;
		if (v > 40'sd2147483647) begin
			r = 32'sh7fffffff;
		end else if (v < -40'sd2147483648) begin
			r = 32'sh80000000;
		end else begin
			r = v[31:0];
		end
		return r;
	endfunction

endpackage

@@ rtl/dro_in_if.sv @@
// ----------------------------------------------------------------------------
// dro_in_if
// Input channel: odometer or orientation word with valid/ready.
// ----------------------------------------------------------------------------
interface dro_in_if;
	logic               valid;
	logic               ready;
	logic               op;
	logic signed [31:0] distance;
	logic        [31:0] timestamp_us;
	logic signed [15:0] quat_x;
	logic signed [15:0] quat_y;
	logic signed [15:0] quat_z;
	logic signed [15:0] quat_w;
	logic signed [15:0] turn_rate;

	modport source(output valid, op, distance, timestamp_us, quat_x, quat_y, quat_z,
		quat_w, turn_rate, input ready);
	modport sink(input valid, op, distance, timestamp_us, quat_x, quat_y, quat_z,
		quat_w, turn_rate, output ready);
endinterface

@@ rtl/dro_out_if.sv @@
// ----------------------------------------------------------------------------
// dro_out_if
// Output channel: position, velocity and heading word with valid/ready.
// ----------------------------------------------------------------------------
interface dro_out_if;
	logic               valid;
	logic               ready;
	logic signed [31:0] pos_x;
	logic signed [31:0] pos_y;
	logic signed [31:0] vel_x;
	logic signed [31:0] vel_y;
	logic signed [16:0] heading;
	logic signed [15:0] heading_rate;

	modport source(output valid, pos_x, pos_y, vel_x, vel_y, heading, heading_rate,
		input ready);
	modport sink(input valid, pos_x, pos_y, vel_x, vel_y, heading, heading_rate,
		output ready);
endinterface

@@ rtl/dro_mul.sv @@
// ----------------------------------------------------------------------------
// dro_mul
// Shared signed multiplier with registered product.
// ----------------------------------------------------------------------------
module dro_mul (
	input  logic                                 clk,
	input  logic signed [dro_pkg::MUL_A_W-1:0]   a,
	input  logic signed [dro_pkg::MUL_B_W-1:0]   b,
	output logic signed [dro_pkg::MUL_P_W-1:0]   p
);
	import dro_pkg::*;

	logic signed [MUL_P_W-1:0] p_q;

	always_ff @(posedge clk) begin
		p_q <= MUL_P_W'(a) * MUL_P_W'(b);
	end

	assign p = p_q;
endmodule

@@ rtl/dro_div.sv @@
// ----------------------------------------------------------------------------
// dro_div
// Unsigned restoring divider, one quotient bit per cycle.
// ----------------------------------------------------------------------------
module dro_div #(
	parameter int N = dro_pkg::DIV_N,
	parameter int D = dro_pkg::DIV_D
) (
	input  logic         clk,
	input  logic         arst_n,
	input  logic         start,
	input  logic [N-1:0] dividend,
	input  logic [D-1:0] divisor,
	output logic         busy,
	output logic [N-1:0] quot
);
	localparam int CW = $clog2(N + 1);

	logic [CW-1:0] cnt_q;
	logic          busy_q;
	logic [D-1:0]  rem_q;
	logic [N-1:0]  quo_q;
	logic [D-1:0]  dvs_q;
	logic [D:0]    trial;
	logic [D+1:0]  diff;
	logic          ge;

	assign trial = {rem_q, quo_q[N-1]};
	assign diff  = {1'b0, trial} - {2'b00, dvs_q};
	assign ge    = ~diff[D+1];

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q <= 1'b0;
			cnt_q  <= '0;
		end else if (start) begin
			busy_q <= 1'b1;
			cnt_q  <= '0;
		end else if (busy_q) begin
			if (cnt_q == CW'(N - 1)) begin
				busy_q <= 1'b0;
			end
			cnt_q <= cnt_q + 1'b1;
		end
	end

	always_ff @(posedge clk) begin
		if (start) begin
			rem_q <= '0;
			quo_q <= dividend;
			dvs_q <= divisor;
		end else if (busy_q) begin
			rem_q <= ge ? diff[D-1:0] : trial[D-1:0];
			quo_q <= {quo_q[N-2:0], ge};
		end
	end

	assign busy = busy_q;
	assign quot = quo_q;
endmodule

@@ rtl/dro_cordic.sv @@
// ----------------------------------------------------------------------------
// dro_cordic
// Iterative CORDIC, vectoring for atan2 or rotation for cos/sin.
// ----------------------------------------------------------------------------
module dro_cordic #(
	parameter int STEPS = dro_pkg::CORDIC_STEPS_DEF
) (
	input  logic                              clk,
	input  logic                              arst_n,
	input  dro_pkg::cordic_ctl_t              ctl,
	input  logic signed [dro_pkg::AW-1:0]     x0,
	input  logic signed [dro_pkg::AW-1:0]     y0,
	input  logic signed [dro_pkg::ZW-1:0]     z0,
	output logic                              busy,
	output logic signed [dro_pkg::AW-1:0]     x,
	output logic signed [dro_pkg::AW-1:0]     y,
	output logic signed [dro_pkg::ZW-1:0]     z
);
	import dro_pkg::*;

	localparam int CW = $clog2(STEPS + 1);

	logic [CW-1:0]        cnt_q;
	logic                 busy_q;
	logic                 rot_q;
	logic signed [AW-1:0] x_q;
	logic signed [AW-1:0] y_q;
	logic signed [ZW-1:0] z_q;
	logic signed [AW-1:0] xs;
	logic signed [AW-1:0] ys;
	logic signed [ZW-1:0] ang;
	logic                 pos;

	assign xs  = x_q >>> cnt_q;
	assign ys  = y_q >>> cnt_q;
	assign ang = {{(ZW - 30){1'b0}}, atan_q30(ATAN_IDX_W'(cnt_q))};
	assign pos = rot_q ? ~z_q[ZW-1] : ~(y_q > 0);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q <= 1'b0;
			cnt_q  <= '0;
		end else if (ctl.start) begin
			busy_q <= 1'b1;
			cnt_q  <= '0;
		end else if (busy_q) begin
			if (cnt_q == CW'(STEPS - 1)) begin
				busy_q <= 1'b0;
			end
			cnt_q <= cnt_q + 1'b1;
		end
	end

	always_ff @(posedge clk) begin
		if (ctl.start) begin
			rot_q <= ctl.rot;
			x_q   <= x0;
			y_q   <= y0;
			z_q   <= z0;
		end else if (busy_q) begin
			if (pos) begin
				x_q <= x_q - ys;
				y_q <= y_q + xs;
				z_q <= z_q - ang;
			end else begin
				x_q <= x_q + ys;
				y_q <= y_q - xs;
				z_q <= z_q + ang;
			end
		end
	end

	assign busy = busy_q;
	assign x    = x_q;
	assign y    = y_q;
	assign z    = z_q;
endmodule

@@ rtl/dead_reckoning_odometry.sv @@
// Orientation word: the time from acceptance to result is set by the shared
// multiplier (24 products) and the CORDIC iterations. Odometer word: time set
// by the 53-step divider; the first one starts no division, nor does one with
// an equal timestamp, whose time the CORDIC alone sets. One word at a time; a
// finished result waits in the output register.
// arst_n clears position, velocity, heading and sets the identity mounting.
// ----------------------------------------------------------------------------
// dead_reckoning_odometry
// Planar dead reckoning from IMU orientation and odometer distance.
// ----------------------------------------------------------------------------
module dead_reckoning_odometry #(
	parameter int CORDIC_STEPS = dro_pkg::CORDIC_STEPS_DEF
) (
	input  logic                              clk,
	input  logic                              arst_n,
	dro_in_if.sink                            in_ch,
	dro_out_if.source                         out_ch,
	input  logic                              cfg_we,
	input  logic [dro_pkg::CFG_IDX_W-1:0]     cfg_index,
	input  logic [dro_pkg::CFG_DATA_W-1:0]    cfg_wdata
);
	import dro_pkg::*;

	typedef enum logic [12:0] {
		S_IDLE    = 13'b0000000000001,
		S_Q_MUL   = 13'b0000000000010,
		S_R_MUL   = 13'b0000000000100,
		S_YAW_CHK = 13'b0000000001000,
		S_YAW_RUN = 13'b0000000010000,
		S_YAW_END = 13'b0000000100000,
		S_D_RED   = 13'b0000001000000,
		S_D_START = 13'b0000010000000,
		S_D_DIV   = 13'b0000100000000,
		S_D_WAIT  = 13'b0001000000000,
		S_D_CS    = 13'b0010000000000,
		S_D_MUL   = 13'b0100000000000,
		S_DONE    = 13'b1000000000000
	} state_t;

	state_t state_q;
	logic [4:0] cnt_q;

	logic signed [15:0] mqx_q, mqy_q, mqz_q, mqw_q;
	logic               op_q;
	logic signed [31:0] dist_q;
	logic        [31:0] time_q;
	logic signed [15:0] qx_q, qy_q, qz_q, qw_q, rate_in_q;

	logic signed [31:0] x_acc_q, y_acc_q, vx_q, vy_q, prev_dist_q;
	logic        [31:0] prev_time_q;
	logic               dist_seen_q, yaw_seen_q;
	logic signed [16:0] yaw_rel_q, yaw_base_q, yaw_q;
	logic signed [15:0] rate_q;

	logic signed [34:0] acc_q;
	logic signed [18:0] rx_q, ry_q, rz_q, rw_q;
	logic signed [37:0] d_q, xa_q, ga_q, ya_q;
	logic signed [32:0] delta_q;
	logic        [31:0] dt_q;
	logic               dtnz_q, neg_q, dneg_q;
	logic signed [ZW-1:0] zr_q;
	logic signed [26:0] c_q, s_q;
	logic signed [31:0] sp_q;

	logic out_valid_q;
	logic signed [31:0] o_px_q, o_py_q, o_vx_q, o_vy_q;
	logic signed [16:0] o_hd_q;
	logic signed [15:0] o_hr_q;

	logic signed [MUL_A_W-1:0] ma;
	logic signed [MUL_B_W-1:0] mb;
	logic signed [MUL_P_W-1:0] mp;

	cordic_ctl_t          cctl;
	logic signed [AW-1:0] cx0, cy0, cx, cy;
	logic signed [ZW-1:0] cz0, cz;
	logic                 cbusy;

	logic              dstart, dbusy;
	logic [DIV_N-1:0]  ddividend, dquot;

	logic              in_acc;
	logic              out_load;
	logic [4:0]        idx5;
	logic [3:0]        idx;
	logic              q_neg;
	logic signed [34:0] pq, q_sum, q_rnd;
	logic signed [37:0] pr;
	logic signed [38:0] gabs, yy;
	logic              yaw_ok;
	logic signed [ZW-1:0] cz_rnd;
	logic signed [16:0] yaw_first;
	logic signed [33:0] zang;
	logic signed [ZW-1:0] zin, zred2;
	logic              neg2;
	logic signed [MUL_P_W-1:0] pd_rnd_full;
	logic signed [36:0] pd_rnd;
	logic signed [39:0] sum_x, sum_y;
	logic signed [53:0] p_sp;
	logic signed [AW-1:0] xv, yv, xr, yr;

	assign in_acc   = in_ch.valid && in_ch.ready;
	assign in_ch.ready = (state_q == S_IDLE);
	assign out_load = (state_q == S_DONE) && (!out_valid_q || out_ch.ready);

	assign idx5  = cnt_q - 5'd1;
	assign idx   = idx5[3:0];
	assign pq    = mp[34:0];
	assign pr    = mp[37:0];

	always_comb begin
		case (idx)
			4'd3, 4'd7, 4'd11, 4'd13, 4'd14, 4'd15: q_neg = 1'b1;
			default:                                 q_neg = 1'b0;
		endcase
	end

	assign q_sum = q_neg ? acc_q - pq : acc_q + pq;
	assign q_rnd = (q_sum + 35'sd16384) >>> 15;

	assign gabs   = ga_q[37] ? -39'(ga_q) : 39'(ga_q);
	assign yy     = 39'(ya_q) <<< 1;
	assign yaw_ok = ((gabs <<< 1) < 39'(d_q)) && !((xa_q == '0) && (ya_q == '0));
	assign cz_rnd = (cz + 36'sd65536) >>> 17;

	assign zang = {yaw_rel_q, 17'd0};
	assign zin  = ZW'(zang);
	always_comb begin
		neg2  = 1'b0;
		zred2 = zr_q;
		if (zr_q > HALFPI_Q30) begin
			zred2 = zr_q - PI_Q30;
			neg2  = 1'b1;
		end else if (zr_q < -HALFPI_Q30) begin
			zred2 = zr_q + PI_Q30;
			neg2  = 1'b1;
		end
	end

	assign pd_rnd_full = (mp + 61'sd8388608) >>> 24;
	assign pd_rnd      = pd_rnd_full[36:0];
	assign sum_x       = 40'(x_acc_q) + 40'(pd_rnd);
	assign sum_y       = 40'(y_acc_q) + 40'(pd_rnd);
	assign p_sp        = mp[53:0];

	assign xv = neg_q ? -cx : cx;
	assign yv = neg_q ? -cy : cy;
	assign xr = (xv + 42'sd32) >>> 6;
	assign yr = (yv + 42'sd32) >>> 6;

	// shared multiplier operands
	always_comb begin
		ma = '0;
		mb = '0;
		unique case (state_q)
			S_Q_MUL: begin
				case (cnt_q[3:0])
					4'd0:  begin ma = MUL_A_W'(mqw_q); mb = MUL_B_W'(qx_q); end
					4'd1:  begin ma = MUL_A_W'(mqx_q); mb = MUL_B_W'(qw_q); end
					4'd2:  begin ma = MUL_A_W'(mqy_q); mb = MUL_B_W'(qz_q); end
					4'd3:  begin ma = MUL_A_W'(mqz_q); mb = MUL_B_W'(qy_q); end
					4'd4:  begin ma = MUL_A_W'(mqw_q); mb = MUL_B_W'(qy_q); end
					4'd5:  begin ma = MUL_A_W'(mqy_q); mb = MUL_B_W'(qw_q); end
					4'd6:  begin ma = MUL_A_W'(mqz_q); mb = MUL_B_W'(qx_q); end
					4'd7:  begin ma = MUL_A_W'(mqx_q); mb = MUL_B_W'(qz_q); end
					4'd8:  begin ma = MUL_A_W'(mqw_q); mb = MUL_B_W'(qz_q); end
					4'd9:  begin ma = MUL_A_W'(mqz_q); mb = MUL_B_W'(qw_q); end
					4'd10: begin ma = MUL_A_W'(mqx_q); mb = MUL_B_W'(qy_q); end
					4'd11: begin ma = MUL_A_W'(mqy_q); mb = MUL_B_W'(qx_q); end
					4'd12: begin ma = MUL_A_W'(mqw_q); mb = MUL_B_W'(qw_q); end
					4'd13: begin ma = MUL_A_W'(mqx_q); mb = MUL_B_W'(qx_q); end
					4'd14: begin ma = MUL_A_W'(mqy_q); mb = MUL_B_W'(qy_q); end
					default: begin ma = MUL_A_W'(mqz_q); mb = MUL_B_W'(qz_q); end
				endcase
			end
			S_R_MUL: begin
				case (cnt_q[2:0])
					3'd0:    begin ma = MUL_A_W'(rx_q); mb = MUL_B_W'(rx_q); end
					3'd1:    begin ma = MUL_A_W'(ry_q); mb = MUL_B_W'(ry_q); end
					3'd2:    begin ma = MUL_A_W'(rz_q); mb = MUL_B_W'(rz_q); end
					3'd3:    begin ma = MUL_A_W'(rw_q); mb = MUL_B_W'(rw_q); end
					3'd4:    begin ma = MUL_A_W'(rx_q); mb = MUL_B_W'(rz_q); end
					3'd5:    begin ma = MUL_A_W'(rw_q); mb = MUL_B_W'(ry_q); end
					3'd6:    begin ma = MUL_A_W'(rx_q); mb = MUL_B_W'(ry_q); end
					default: begin ma = MUL_A_W'(rw_q); mb = MUL_B_W'(rz_q); end
				endcase
			end
			S_D_START: begin
				ma = MUL_A_W'(delta_q);
				mb = SPEED_SCALE;
			end
			S_D_MUL: begin
				case (cnt_q[1:0])
					2'd0:    begin ma = MUL_A_W'(delta_q); mb = c_q; end
					2'd1:    begin ma = MUL_A_W'(delta_q); mb = s_q; end
					2'd2:    begin ma = MUL_A_W'(sp_q);    mb = c_q; end
					default: begin ma = MUL_A_W'(sp_q);    mb = s_q; end
				endcase
			end
			default: begin
				ma = '0;
				mb = '0;
			end
		endcase
	end

	// cordic start and seed
	always_comb begin
		cctl.start = 1'b0;
		cctl.rot   = 1'b0;
		cx0 = AW'(xa_q);
		cy0 = AW'(yy);
		cz0 = '0;
		if (state_q == S_D_START) begin
			cctl.start = 1'b1;
			cctl.rot   = 1'b1;
			cx0 = GAIN_Q30;
			cy0 = '0;
			cz0 = zred2;
		end else if (state_q == S_YAW_CHK) begin
			cctl.start = yaw_ok;
			if (xa_q[37]) begin
				if (!yy[38]) begin
					cx0 = AW'(yy);
					cy0 = -AW'(xa_q);
					cz0 = HALFPI_Q30;
				end else begin
					cx0 = -AW'(yy);
					cy0 = AW'(xa_q);
					cz0 = -HALFPI_Q30;
				end
			end
		end
	end

	assign dstart    = (state_q == S_D_DIV) && dtnz_q;
	assign ddividend = p_sp[53] ? DIV_N'(-p_sp) : DIV_N'(p_sp);

	dro_mul u_mul (
		.clk (clk),
		.a   (ma),
		.b   (mb),
		.p   (mp)
	);

	dro_cordic #(.STEPS(CORDIC_STEPS)) u_cordic (
		.clk    (clk),
		.arst_n (arst_n),
		.ctl    (cctl),
		.x0     (cx0),
		.y0     (cy0),
		.z0     (cz0),
		.busy   (cbusy),
		.x      (cx),
		.y      (cy),
		.z      (cz)
	);

	dro_div #(.N(DIV_N), .D(DIV_D)) u_div (
		.clk      (clk),
		.arst_n   (arst_n),
		.start    (dstart),
		.dividend (ddividend),
		.divisor  (dt_q),
		.busy     (dbusy),
		.quot     (dquot)
	);

	assign yaw_first = yaw_seen_q ? yaw_base_q : yaw_q;

	// sequencer and state
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= S_IDLE;
			cnt_q       <= '0;
			mqx_q       <= '0;
			mqy_q       <= '0;
			mqz_q       <= '0;
			mqw_q       <= MOUNT_QW_RST;
			x_acc_q     <= '0;
			y_acc_q     <= '0;
			vx_q        <= '0;
			vy_q        <= '0;
			prev_dist_q <= '0;
			prev_time_q <= '0;
			dist_seen_q <= 1'b0;
			yaw_rel_q   <= '0;
			yaw_base_q  <= '0;
			yaw_seen_q  <= 1'b0;
			rate_q      <= '0;
			out_valid_q <= 1'b0;
		end else begin
			if (cfg_we) begin
				unique case (cfg_index)
					REG_MOUNT_QX: mqx_q <= cfg_wdata;
					REG_MOUNT_QY: mqy_q <= cfg_wdata;
					REG_MOUNT_QZ: mqz_q <= cfg_wdata;
					REG_MOUNT_QW: mqw_q <= cfg_wdata;
					default:      mqx_q <= mqx_q;
				endcase
			end
			if (out_load) begin
				out_valid_q <= 1'b1;
			end else if (out_ch.ready) begin
				out_valid_q <= 1'b0;
			end
			unique case (state_q)
				S_IDLE: begin
					cnt_q <= '0;
					if (in_acc) begin
						if (in_ch.op) begin
							state_q <= S_Q_MUL;
						end else if (dist_seen_q) begin
							state_q <= S_D_RED;
						end else begin
							state_q <= S_YAW_END;
						end
					end
				end
				S_Q_MUL: begin
					cnt_q <= cnt_q + 5'd1;
					if (cnt_q == 5'd16) begin
						cnt_q   <= '0;
						state_q <= S_R_MUL;
					end
				end
				S_R_MUL: begin
					cnt_q <= cnt_q + 5'd1;
					if (cnt_q == 5'd8) begin
						state_q <= S_YAW_CHK;
					end
				end
				S_YAW_CHK: begin
					state_q <= yaw_ok ? S_YAW_RUN : S_YAW_END;
				end
				S_YAW_RUN: begin
					if (!cbusy) begin
						state_q <= S_YAW_END;
					end
				end
				S_YAW_END: begin
					if (op_q) begin
						yaw_base_q <= yaw_first;
						yaw_seen_q <= 1'b1;
						yaw_rel_q  <= yaw_q - yaw_first;
						rate_q     <= rate_in_q;
					end else begin
						dist_seen_q <= 1'b1;
						prev_dist_q <= dist_q;
						prev_time_q <= time_q;
					end
					state_q <= S_DONE;
				end
				S_D_RED:   state_q <= S_D_START;
				S_D_START: state_q <= S_D_DIV;
				S_D_DIV:   state_q <= S_D_WAIT;
				S_D_WAIT: begin
					if (!cbusy && !dbusy) begin
						state_q <= S_D_CS;
					end
				end
				S_D_CS: begin
					cnt_q   <= '0;
					state_q <= S_D_MUL;
				end
				S_D_MUL: begin
					cnt_q <= cnt_q + 5'd1;
					if (cnt_q != 5'd0) begin
						case (idx[1:0])
							2'd0: x_acc_q <= sat32(sum_x);
							2'd1: y_acc_q <= sat32(sum_y);
							2'd2: if (dtnz_q) vx_q <= sat32(40'(pd_rnd));
							default: if (dtnz_q) vy_q <= sat32(40'(pd_rnd));
						endcase
					end
					if (cnt_q == 5'd4) begin
						state_q <= S_YAW_END;
					end
				end
				S_DONE: begin
					if (out_load) begin
						state_q <= S_IDLE;
					end
				end
				default: state_q <= S_IDLE;
			endcase
		end
	end

	// working registers
	always_ff @(posedge clk) begin
		if (in_acc) begin
			op_q      <= in_ch.op;
			dist_q    <= in_ch.distance;
			time_q    <= in_ch.timestamp_us;
			qx_q      <= in_ch.quat_x;
			qy_q      <= in_ch.quat_y;
			qz_q      <= in_ch.quat_z;
			qw_q      <= in_ch.quat_w;
			rate_in_q <= in_ch.turn_rate;
			acc_q     <= '0;
			d_q       <= '0;
			xa_q      <= '0;
			ga_q      <= '0;
			ya_q      <= '0;
			yaw_q     <= '0;
		end
		if (state_q == S_Q_MUL && cnt_q != 5'd0) begin
			if (idx[1:0] == 2'd3) begin
				acc_q <= '0;
				case (idx[3:2])
					2'd0:    rx_q <= q_rnd[18:0];
					2'd1:    ry_q <= q_rnd[18:0];
					2'd2:    rz_q <= q_rnd[18:0];
					default: rw_q <= q_rnd[18:0];
				endcase
			end else begin
				acc_q <= q_sum;
			end
		end
		if (state_q == S_R_MUL && cnt_q != 5'd0) begin
			case (idx[2:0])
				3'd0, 3'd3: begin d_q <= d_q + pr; xa_q <= xa_q + pr; end
				3'd1, 3'd2: begin d_q <= d_q + pr; xa_q <= xa_q - pr; end
				3'd4:       ga_q <= ga_q + pr;
				3'd5:       ga_q <= ga_q - pr;
				default:    ya_q <= ya_q + pr;
			endcase
		end
		if (state_q == S_YAW_RUN && !cbusy) begin
			yaw_q <= cz_rnd[16:0];
		end
		if (state_q == S_D_RED) begin
			delta_q <= 33'(dist_q) - 33'(prev_dist_q);
			dt_q    <= time_q - prev_time_q;
			dtnz_q  <= (time_q != prev_time_q);
			if (zin > PI_Q30) begin
				zr_q <= zin - TWOPI_Q30;
			end else if (zin < -PI_Q30) begin
				zr_q <= zin + TWOPI_Q30;
			end else begin
				zr_q <= zin;
			end
		end
		if (state_q == S_D_START) begin
			neg_q <= neg2;
		end
		if (state_q == S_D_DIV) begin
			dneg_q <= p_sp[53];
		end
		if (state_q == S_D_CS) begin
			c_q <= xr[26:0];
			s_q <= yr[26:0];
			if (!dneg_q) begin
				sp_q <= (dquot > DIV_N'(32'h7fffffff)) ? 32'sh7fffffff : dquot[31:0];
			end else begin
				sp_q <= (dquot >= DIV_N'(33'h080000000)) ? 32'sh80000000 : -dquot[31:0];
			end
		end
		if (out_load) begin
			o_px_q <= x_acc_q;
			o_py_q <= y_acc_q;
			o_vx_q <= vx_q;
			o_vy_q <= vy_q;
			o_hd_q <= yaw_rel_q;
			o_hr_q <= rate_q;
		end
	end

	assign out_ch.valid        = out_valid_q;
	assign out_ch.pos_x        = o_px_q;
	assign out_ch.pos_y        = o_py_q;
	assign out_ch.vel_x        = o_vx_q;
	assign out_ch.vel_y        = o_vy_q;
	assign out_ch.heading      = o_hd_q;
	assign out_ch.heading_rate = o_hr_q;

	a_done_to_idle: assert property (@(posedge clk) disable iff (!arst_n)
		out_load |=> out_valid_q && state_q == S_IDLE)
		else $error("result word not presented after completion");

	a_units_idle: assert property (@(posedge clk) disable iff (!arst_n)
		state_q == S_D_CS |-> !cbusy && !dbusy)
		else $error("cos/sin or speed taken while a unit is still busy");

	a_dist_sticky: assert property (@(posedge clk) disable iff (!arst_n)
		dist_seen_q |=> dist_seen_q)
		else $error("odometer history lost");

	a_accept_busy: assert property (@(posedge clk) disable iff (!arst_n)
		in_acc |=> state_q != S_IDLE)
		else $error("input word accepted without starting work");
endmodule

@@ dv/dro_checker.sv @@
// ----------------------------------------------------------------------------
// dro_checker
// Watches the input, output and register ports of the dead-reckoning block,
// keeps its own copy of the odometry state, forecasts every result word and
// compares the words that leave the block against that forecast in order.
// ----------------------------------------------------------------------------
module dro_checker #(
	parameter int CORDIC_STEPS = dro_pkg::CORDIC_STEPS_DEF
) (
	input  logic                           clk,
	input  logic                           arst_n,
	dro_in_if.sink                         in_ch,
	dro_out_if.sink                        out_ch,
	input  logic                           cfg_we,
	input  logic [dro_pkg::CFG_IDX_W-1:0]  cfg_index,
	input  logic [dro_pkg::CFG_DATA_W-1:0] cfg_wdata,
	output int                             fail_count,
	output int                             pending
);
	import dro_pkg::*;

	typedef struct packed {
		logic signed [31:0] pos_x;
		logic signed [31:0] pos_y;
		logic signed [31:0] vel_x;
		logic signed [31:0] vel_y;
		logic signed [16:0] heading;
		logic signed [15:0] heading_rate;
	} nav_word_t;

	localparam longint PI_L     = 64'sd3373259426;
	localparam longint HALFPI_L = 64'sd1686629713;
	localparam longint TWOPI_L  = 64'sd6746518852;
	localparam longint GAIN_L   = 64'sd652032874;

	nav_word_t nav_queue[$];

	longint mqx, mqy, mqz, mqw;
	longint x_pos, y_pos, vx, vy, last_dist;
	logic [31:0] last_time;
	logic dist_valid, yaw_valid;
	longint yaw_rel_q, yaw_base_q, rate_q;

	function automatic longint angle_step(input int i);
		longint tab[24];
		tab = '{843314857, 497837829, 263043837, 133525159, 67021687, 33543516,
			16775851, 8388437, 4194283, 2097149, 1048576, 524288, 262144, 131072,
			65536, 32768, 16384, 8192, 4096, 2048, 1024, 512, 256, 128};
		return tab[i];
	endfunction

	function automatic longint round_shift(input longint v, input int s);
		return (v + (64'sd1 <<< (s - 1))) >>> s;
	endfunction

	function automatic longint clamp32(input longint v);
		if (v > 64'sd2147483647) return 64'sd2147483647;
		if (v < -64'sd2147483648) return -64'sd2147483648;
		return v;
	endfunction

	function automatic longint wrap17(input longint v);
		logic signed [16:0] t;
		t = v[16:0];
		return longint'(t);
	endfunction

	function automatic longint vector_angle(input longint yi, input longint xi);
		longint z, t, xs, ys, x, y;
		x = xi;
		y = yi;
		z = 0;
		if (x == 0 && y == 0) return 0;
		if (x < 0) begin
			if (y >= 0) begin
				t = x; x = y; y = -t; z = HALFPI_L;
			end else begin
				t = x; x = -y; y = t; z = -HALFPI_L;
			end
		end
		for (int i = 0; i < CORDIC_STEPS && i < MAX_STEPS; i++) begin
			xs = x >>> i;
			ys = y >>> i;
			if (y > 0) begin
				x += ys; y -= xs; z += angle_step(i);
			end else begin
				x -= ys; y += xs; z -= angle_step(i);
			end
		end
		return z;
	endfunction

	task automatic heading_cos_sin(input longint ang, output longint c, output longint s);
		longint z, x, y, xs, ys;
		bit flip;
		z = ang * 131072;
		x = GAIN_L;
		y = 0;
		flip = 0;
		while (z > PI_L) z -= TWOPI_L;
		while (z < -PI_L) z += TWOPI_L;
		if (z > HALFPI_L) begin
			z -= PI_L; flip = 1;
		end else if (z < -HALFPI_L) begin
			z += PI_L; flip = 1;
		end
		for (int i = 0; i < CORDIC_STEPS && i < MAX_STEPS; i++) begin
			xs = x >>> i;
			ys = y >>> i;
			if (z >= 0) begin
				x -= ys; y += xs; z -= angle_step(i);
			end else begin
				x += ys; y -= xs; z += angle_step(i);
			end
		end
		if (flip) begin
			x = -x; y = -y;
		end
		c = round_shift(x, 6);
		s = round_shift(y, 6);
	endtask

	task automatic advance_nav(input logic op, input logic signed [31:0] odo_d,
		input logic [31:0] ts, input logic signed [15:0] qx, input logic signed [15:0] qy,
		input logic signed [15:0] qz, input logic signed [15:0] qw,
		input logic signed [15:0] rate);
		longint rx, ry, rz, rw, d, g, yaw, delta, c, s, sp;
		logic [31:0] dt;
		nav_word_t w;
		if (op) begin
			rx = round_shift(mqw * qx + mqx * qw + mqy * qz - mqz * qy, 15);
			ry = round_shift(mqw * qy + mqy * qw + mqz * qx - mqx * qz, 15);
			rz = round_shift(mqw * qz + mqz * qw + mqx * qy - mqy * qx, 15);
			rw = round_shift(mqw * qw - mqx * qx - mqy * qy - mqz * qz, 15);
			d = rx * rx + ry * ry + rz * rz + rw * rw;
			g = 2 * (rx * rz - rw * ry);
			if (g < 0) g = -g;
			yaw = 0;
			if (g < d)
				yaw = round_shift(vector_angle(2 * (rx * ry + rw * rz),
					rw * rw + rx * rx - ry * ry - rz * rz), 17);
			if (!yaw_valid) begin
				yaw_base_q = yaw;
				yaw_valid = 1;
			end
			yaw_rel_q = wrap17(yaw - yaw_base_q);
			rate_q = rate;
		end else begin
			if (dist_valid) begin
				delta = longint'(odo_d) - last_dist;
				dt = ts - last_time;
				heading_cos_sin(yaw_rel_q, c, s);
				if (dt != 0) begin
					sp = clamp32(delta * 1000000 / longint'({32'd0, dt}));
					vx = clamp32(round_shift(sp * c, 24));
					vy = clamp32(round_shift(sp * s, 24));
				end
				x_pos = clamp32(x_pos + round_shift(delta * c, 24));
				y_pos = clamp32(y_pos + round_shift(delta * s, 24));
			end
			dist_valid = 1;
			last_dist = odo_d;
			last_time = ts;
		end
		w.pos_x = x_pos[31:0];
		w.pos_y = y_pos[31:0];
		w.vel_x = vx[31:0];
		w.vel_y = vy[31:0];
		w.heading = yaw_rel_q[16:0];
		w.heading_rate = rate_q[15:0];
		nav_queue.push_back(w);
	endtask

	task automatic report(input string what, input longint got, input longint want);
		$display("mismatch %s: got %0d want %0d", what, got, want);
		fail_count++;
	endtask

	assign pending = nav_queue.size();

	always @(posedge clk or negedge arst_n) begin
		nav_word_t e;
		if (!arst_n) begin
			mqx = 0; mqy = 0; mqz = 0; mqw = 32767;
			x_pos = 0; y_pos = 0; vx = 0; vy = 0; last_dist = 0; last_time = 0;
			dist_valid = 0; yaw_valid = 0; yaw_rel_q = 0; yaw_base_q = 0; rate_q = 0;
			fail_count = 0;
			nav_queue.delete();
		end else begin
			if (out_ch.valid && out_ch.ready) begin
				if (nav_queue.size() == 0) begin
					report("unexpected word", 0, 0);
				end else begin
					e = nav_queue.pop_front();
					if (out_ch.pos_x !== e.pos_x) report("pos_x", out_ch.pos_x, e.pos_x);
					if (out_ch.pos_y !== e.pos_y) report("pos_y", out_ch.pos_y, e.pos_y);
					if (out_ch.vel_x !== e.vel_x) report("vel_x", out_ch.vel_x, e.vel_x);
					if (out_ch.vel_y !== e.vel_y) report("vel_y", out_ch.vel_y, e.vel_y);
					if (out_ch.heading !== e.heading)
						report("heading", out_ch.heading, e.heading);
					if (out_ch.heading_rate !== e.heading_rate)
						report("heading_rate", out_ch.heading_rate, e.heading_rate);
				end
			end
			if (in_ch.valid && in_ch.ready)
				advance_nav(in_ch.op, in_ch.distance, in_ch.timestamp_us, in_ch.quat_x,
					in_ch.quat_y, in_ch.quat_z, in_ch.quat_w, in_ch.turn_rate);
			if (cfg_we) begin
				case (cfg_index)
					REG_MOUNT_QX: mqx = longint'($signed(cfg_wdata));
					REG_MOUNT_QY: mqy = longint'($signed(cfg_wdata));
					REG_MOUNT_QZ: mqz = longint'($signed(cfg_wdata));
					REG_MOUNT_QW: mqw = longint'($signed(cfg_wdata));
					default: ;
				endcase
			end
		end
	end
endmodule

@@ dv/tb_top.sv @@
// ----------------------------------------------------------------------------
// tb_top
// Drives orientation and odometer words into the dead-reckoning block through
// several mounting settings and idling patterns, including a long output
// hold-off, and reports the verdict from the checker's failure count.
// ----------------------------------------------------------------------------
module tb_top;
	import dro_pkg::*;

	logic clk = 0;
	logic arst_n = 0;
	logic cfg_we = 0;
	logic [CFG_IDX_W-1:0] cfg_index = '0;
	logic [CFG_DATA_W-1:0] cfg_wdata = '0;
	int fail_count, pending;
	int src_idle = 0, snk_idle = 0;
	bit hold_off = 0;
	longint cycles = 0;
	logic signed [31:0] odo_dist = 0;
	logic [31:0] odo_time = 0;

	dro_in_if  in_ch();
	dro_out_if out_ch();

	dead_reckoning_odometry dut (.clk(clk), .arst_n(arst_n), .in_ch(in_ch.sink),
		.out_ch(out_ch.source), .cfg_we(cfg_we), .cfg_index(cfg_index),
		.cfg_wdata(cfg_wdata));

	dro_checker chk (.clk(clk), .arst_n(arst_n), .in_ch(in_ch.sink),
		.out_ch(out_ch.sink), .cfg_we(cfg_we), .cfg_index(cfg_index),
		.cfg_wdata(cfg_wdata), .fail_count(fail_count), .pending(pending));

	always begin
		#2 clk = 1;
		#2 clk = 0;
	end

	initial begin
		in_ch.valid = 0; in_ch.op = 0; in_ch.distance = 0; in_ch.timestamp_us = 0;
		in_ch.quat_x = 0; in_ch.quat_y = 0; in_ch.quat_z = 0; in_ch.quat_w = 0;
		in_ch.turn_rate = 0;
		out_ch.ready = 0;
	end

	always @(posedge clk) begin
		cycles <= cycles + 1;
		if (cycles > 64'd3000000) begin
			$display("tb: failure");
			$finish;
		end
	end

	// receiver, with a long hold-off counted here
	always @(negedge clk) begin
		int hold_cnt;
		if (hold_off) begin
			out_ch.ready <= 0;
			hold_cnt = 0;
			while (hold_cnt < 2000) begin
				@(negedge clk);
				hold_cnt++;
			end
			hold_off = 0;
		end
		out_ch.ready <= ($urandom_range(99) >= snk_idle);
	end

	task automatic send_word(input logic op, input logic signed [31:0] dist_v,
		input logic [31:0] ts, input logic signed [15:0] qx, input logic signed [15:0] qy,
		input logic signed [15:0] qz, input logic signed [15:0] qw,
		input logic signed [15:0] rate);
		while ($urandom_range(99) < src_idle) begin
			in_ch.valid <= 0;
			@(negedge clk);
		end
		in_ch.valid <= 1;
		in_ch.op <= op; in_ch.distance <= dist_v; in_ch.timestamp_us <= ts;
		in_ch.quat_x <= qx; in_ch.quat_y <= qy; in_ch.quat_z <= qz; in_ch.quat_w <= qw;
		in_ch.turn_rate <= rate;
		do @(posedge clk); while (!in_ch.ready);
		@(negedge clk);
	endtask

	task automatic send_quat(input logic signed [15:0] qx, input logic signed [15:0] qy,
		input logic signed [15:0] qz, input logic signed [15:0] qw);
		send_word(1'b1, $urandom, $urandom, qx, qy, qz, qw, 16'($urandom));
	endtask

	task automatic send_odo(input logic signed [31:0] dist_v, input logic [31:0] ts);
		send_word(1'b0, dist_v, ts, 16'($urandom), 16'($urandom), 16'($urandom),
			16'($urandom), 16'($urandom));
	endtask

	task automatic drain;
		in_ch.valid <= 0;
		while (pending != 0) @(negedge clk);
		repeat (80) @(negedge clk);
	endtask

	task automatic set_mount(input logic [15:0] ax, input logic [15:0] ay,
		input logic [15:0] az, input logic [15:0] aw);
		logic [15:0] v[4];
		v = '{ax, ay, az, aw};
		drain();
		for (int i = 0; i < 4; i++) begin
			cfg_we <= 1;
			cfg_index <= i[CFG_IDX_W-1:0];
			cfg_wdata <= v[i];
			@(negedge clk);
		end
		cfg_we <= 0;
	endtask

	task automatic random_item;
		int r;
		r = $urandom_range(99);
		if (r < 45) begin
			// mostly small steps forward with moderate time gaps
			odo_dist = odo_dist + $signed($urandom_range(200000)) - 50000;
			odo_time = odo_time + $urandom_range(20000);
			send_odo(odo_dist, odo_time);
		end else if (r < 55) begin
			odo_dist = $urandom;
			odo_time = $urandom;
			send_odo(odo_dist, odo_time);
		end else if (r < 60) begin
			send_odo(odo_dist, odo_time);
		end else if (r < 90) begin
			send_quat(16'($signed($urandom_range(4000)) - 2000),
				16'($signed($urandom_range(4000)) - 2000), 16'($urandom), 16'($urandom));
		end else begin
			send_quat(16'($urandom), 16'($urandom), 16'($urandom), 16'($urandom));
		end
	endtask

	initial begin
		repeat (5) @(negedge clk);
		arst_n = 1;
		src_idle = 29; snk_idle = 80;
		// directed: identity mounting, first yaw, extremes
		send_quat(0, 0, 0, 16'sh7fff);
		send_odo(0, 0);
		send_odo(32'sd65536, 32'd1000);
		send_odo(32'sd65536, 32'd1000);
		send_quat(0, 0, 16'sh5a82, 16'sh5a82);
		send_odo(32'sh7fffffff, 32'd1);
		send_odo(32'sh80000000, 32'd0);
		send_odo(32'sh7fffffff, 32'hffffffff);
		send_odo(32'sh7fffffff, 32'd5);
		send_quat(0, 0, 0, 0);
		send_quat(16'sh5a82, 0, 16'sh5a82, 0);
		send_quat(0, 0, 16'sh7fff, 16'sh8000);
		send_quat(0, 0, 16'sh8000, 16'sh8000);
		send_quat(16'sh8000, 16'sh8000, 16'sh8000, 16'sh8000);
		send_quat(16'sh7fff, 16'sh7fff, 16'sh7fff, 16'sh7fff);
		send_word(1'b1, 0, 0, 0, 0, 16'sh7fff, 16'sh0001, 16'sh7fff);
		send_word(1'b1, 0, 0, 0, 0, 16'sh8001, 16'sh0001, 16'sh8000);
		send_odo(32'sd0, 32'd100);
		send_odo(32'sh40000000, 32'd101);
		set_mount(16'sh8000, 16'sh7fff, 16'sh8000, 16'sh7fff);
		send_quat(16'sh1234, 16'sh8000, 16'sh7fff, 16'sh0f00);
		send_odo(32'sd1000, 32'd200);
		for (int i = 0; i < 600; i++) begin
			if (i == 300) hold_off = 1;
			random_item();
		end
		set_mount(16'($urandom), 16'($urandom), 16'($urandom), 16'($urandom));
		src_idle = 80; snk_idle = 29;
		for (int i = 0; i < 600; i++) random_item();
		set_mount(0, 0, 16'sh5a82, 16'sh5a82);
		src_idle = 0; snk_idle = 0;
		for (int i = 0; i < 400; i++) random_item();
		set_mount(16'sh8000, 0, 0, 0);
		for (int i = 0; i < 400; i++) random_item();
		drain();
		if (fail_count == 0) begin
			$display("tb: success");
		end else begin
			$display("tb: failure");
		end
		$finish;
	end
endmodule

@@ filelist.f @@
rtl/dro_pkg.sv
rtl/dro_in_if.sv
rtl/dro_out_if.sv
rtl/dro_mul.sv
rtl/dro_div.sv
rtl/dro_cordic.sv
rtl/dead_reckoning_odometry.sv
dv/dro_checker.sv
dv/tb_top.sv
